/* hw/rtl/cwc_pkg.sv */
// Shared types and constants for the circle versus thick-wall collision tester.
// Used by every module of the block; depends on nothing.
package cwc_pkg;

  // Default wall table depth
  localparam int MAX_WALLS_DEFAULT = 64;

  // Command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 15;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0]  MAP_WIDTH_RESET  = 15'd25600;
  localparam logic [CFG_DATA_W-1:0]  MAP_HEIGHT_RESET = 15'd19200;

  // One request: command plus query circle plus new wall
  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [13:0]        radius;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [11:0]        thickness;
  } req_t;

  // One response
  typedef struct packed {
    logic collides;
    logic status;
  } rsp_t;

  // Stored wall record (76 bits)
  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic [11:0]        th;
  } wall_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_REPLY
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;    // request accepted this cycle
    logic check;   // run the border test
    logic issue;   // read the next wall into the pipe
    logic reply;   // load the response register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_query;    // incoming request is a query
    logic bound_exit;  // circle leaves the map
    logic empty;       // no walls stored
    logic issue_last;  // current read index is the last stored wall
    logic pipe_busy;   // wall reads still in flight
  } stat_t;

endpackage

/* hw/rtl/cwc_wall_pipe.sv */
// Pipelined exact circle versus thick-segment test, one wall per cycle.
// Depends on cwc_pkg for the wall record type.
module cwc_wall_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               wall_valid,
  input  cwc_pkg::wall_t     wall,
  input  logic signed [15:0] px,
  input  logic signed [15:0] py,
  input  logic [13:0]        radius,
  output logic               hit_valid,
  output logic               hit,
  output logic               busy
);

  logic v1, v2, v3, v4, v5;

  // Stage 1: differences and reach = 2r + thickness
  logic signed [16:0] s1_dx, s1_dy, s1_wx, s1_wy, s1_bx, s1_by;
  logic [15:0]        s1_reach;

  always_ff @(posedge clk) begin
    s1_dx    <= 17'($signed(wall.ex)) - 17'($signed(wall.sx));
    s1_dy    <= 17'($signed(wall.ey)) - 17'($signed(wall.sy));
    s1_wx    <= 17'(px) - 17'($signed(wall.sx));
    s1_wy    <= 17'(py) - 17'($signed(wall.sy));
    s1_bx    <= 17'(px) - 17'($signed(wall.ex));
    s1_by    <= 17'(py) - 17'($signed(wall.ey));
    s1_reach <= 16'({radius, 1'b0}) + 16'(wall.th);
  end

  // Stage 2: all squares and cross terms, one multiplier each
  logic signed [33:0] m_dxx, m_dyy, m_wxdx, m_wydy, m_wxdy, m_wydx;
  logic signed [33:0] m_wxx, m_wyy, m_bxx, m_byy;
  logic [31:0]        m_reach2;

  assign m_dxx    = s1_dx * s1_dx;
  assign m_dyy    = s1_dy * s1_dy;
  assign m_wxdx   = s1_wx * s1_dx;
  assign m_wydy   = s1_wy * s1_dy;
  assign m_wxdy   = s1_wx * s1_dy;
  assign m_wydx   = s1_wy * s1_dx;
  assign m_wxx    = s1_wx * s1_wx;
  assign m_wyy    = s1_wy * s1_wy;
  assign m_bxx    = s1_bx * s1_bx;
  assign m_byy    = s1_by * s1_by;
  assign m_reach2 = s1_reach * s1_reach;

  logic signed [33:0] s2_dxx, s2_dyy, s2_wxdx, s2_wydy, s2_wxdy, s2_wydx;
  logic signed [33:0] s2_wxx, s2_wyy, s2_bxx, s2_byy;
  logic [30:0]        s2_reach2;

  always_ff @(posedge clk) begin
    s2_dxx    <= m_dxx;
    s2_dyy    <= m_dyy;
    s2_wxdx   <= m_wxdx;
    s2_wydy   <= m_wydy;
    s2_wxdy   <= m_wxdy;
    s2_wydx   <= m_wydx;
    s2_wxx    <= m_wxx;
    s2_wyy    <= m_wyy;
    s2_bxx    <= m_bxx;
    s2_byy    <= m_byy;
    s2_reach2 <= m_reach2[30:0];
  end

  // Stage 3: length squared, projection, cross product, endpoint distances
  logic [32:0]        s3_len2, s3_d2s, s3_d2e;
  logic signed [34:0] s3_proj, s3_cross;
  logic [30:0]        s3_reach2;

  always_ff @(posedge clk) begin
    s3_len2   <= 33'(s2_dxx[31:0]) + 33'(s2_dyy[31:0]);
    s3_d2s    <= 33'(s2_wxx[31:0]) + 33'(s2_wyy[31:0]);
    s3_d2e    <= 33'(s2_bxx[31:0]) + 33'(s2_byy[31:0]);
    s3_proj   <= 35'(s2_wxdx) + 35'(s2_wydy);
    s3_cross  <= 35'(s2_wxdy) - 35'(s2_wydx);
    s3_reach2 <= s2_reach2;
  end

  // Stage 4: pick the region, decide endpoint cases, split the wide products
  logic               zero_len, near_start, near_end;
  logic               hit_start, hit_end;
  logic signed [17:0] cr_hi, cr_lo;
  logic [15:0]        len_hi;
  logic [16:0]        len_lo;
  logic signed [35:0] m_chh, m_chl;
  logic [33:0]        m_cll;
  logic [47:0]        m_rl0;
  logic [46:0]        m_rl1;

  assign zero_len   = (s3_len2 == '0);
  assign near_start = (s3_proj <= 35'sd0);
  assign near_end   = (s3_proj >= $signed({2'b00, s3_len2}));
  assign hit_start  = ({s3_d2s, 2'b00} < 35'(s3_reach2));
  assign hit_end    = ({s3_d2e, 2'b00} < 35'(s3_reach2));

  // cross = cr_hi * 2^17 + cr_lo, cr_lo non-negative
  assign cr_hi  = s3_cross[34:17];
  assign cr_lo  = $signed({1'b0, s3_cross[16:0]});
  assign len_hi = s3_len2[32:17];
  assign len_lo = s3_len2[16:0];

  assign m_chh = cr_hi * cr_hi;
  assign m_chl = cr_hi * cr_lo;
  assign m_cll = s3_cross[16:0] * s3_cross[16:0];
  assign m_rl0 = s3_reach2 * len_lo;
  assign m_rl1 = s3_reach2 * len_hi;

  logic               s4_interior, s4_end_hit;
  logic signed [35:0] s4_chh, s4_chl;
  logic [33:0]        s4_cll;
  logic [47:0]        s4_rl0;
  logic [46:0]        s4_rl1;

  always_ff @(posedge clk) begin
    s4_interior <= !zero_len && !near_start && !near_end;
    s4_end_hit  <= !zero_len && (near_start ? hit_start : (near_end && hit_end));
    s4_chh      <= m_chh;
    s4_chl      <= m_chl;
    s4_cll      <= m_cll;
    s4_rl0      <= m_rl0;
    s4_rl1      <= m_rl1;
  end

  // Stage 5: reassemble 4*cross^2 and reach^2 * len^2
  logic [71:0] cross_sq;
  logic [63:0] reach_len;

  assign cross_sq  = (72'(s4_chh) << 34) + (72'(s4_chl) << 18) + 72'(s4_cll);
  assign reach_len = 64'(s4_rl0) + (64'(s4_rl1) << 17);

  logic        s5_interior, s5_end_hit;
  logic [67:0] s5_lhs;
  logic [63:0] s5_rhs;

  always_ff @(posedge clk) begin
    s5_interior <= s4_interior;
    s5_end_hit  <= s4_end_hit;
    s5_lhs      <= {cross_sq[65:0], 2'b00};
    s5_rhs      <= reach_len;
  end

  // Final compare
  assign hit_valid = v5;
  assign hit       = s5_interior ? (s5_lhs < 68'(s5_rhs)) : s5_end_hit;
  assign busy      = v1 | v2 | v3 | v4 | v5;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= wall_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

endmodule

/* hw/rtl/cwc_datapath.sv */
// Datapath: map registers, wall table memory, query registers, border test,
// wall read sequencing and the response register. Depends on cwc_pkg, cwc_wall_pipe.
module cwc_datapath #(
  parameter int MAX_WALLS = cwc_pkg::MAX_WALLS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cwc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cwc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  cwc_pkg::req_t                   req,
  input  cwc_pkg::cmd_t                   cmd,
  output cwc_pkg::stat_t                  stat,
  output cwc_pkg::rsp_t                   rsp
);

  localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CW = $clog2(MAX_WALLS + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_WALLS);

  // Map size registers
  logic [cwc_pkg::CFG_DATA_W-1:0] map_w, map_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_w <= cwc_pkg::MAP_WIDTH_RESET;
      map_h <= cwc_pkg::MAP_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cwc_pkg::REG_MAP_WIDTH:  map_w <= cfg_data;
        cwc_pkg::REG_MAP_HEIGHT: map_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // Wall count
  logic [CW-1:0] wall_count;
  logic          full;
  logic          do_add;

  assign full   = (wall_count == COUNT_MAX);
  assign do_add = cmd.take && (req.command == cwc_pkg::CMD_ADD) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_count <= '0;
    end else if (cmd.take) begin
      if (req.command == cwc_pkg::CMD_CLEAR) begin
        wall_count <= '0;
      end else if (do_add) begin
        wall_count <= wall_count + CW'(1);
      end
    end
  end

  // Wall table: written on add, read one entry per issue
  cwc_pkg::wall_t wall_mem [MAX_WALLS];
  cwc_pkg::wall_t new_wall;
  cwc_pkg::wall_t rd_wall;
  logic           rd_valid;
  logic [AW-1:0]  idx;

  assign new_wall = '{sx: req.start_x, sy: req.start_y, ex: req.end_x, ey: req.end_y,
                      th: req.thickness};

  always_ff @(posedge clk) begin
    if (do_add) begin
      wall_mem[wall_count[AW-1:0]] <= new_wall;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_wall <= wall_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      idx      <= '0;
    end else begin
      rd_valid <= cmd.issue;
      if (cmd.take) begin
        idx <= '0;
      end else if (cmd.issue) begin
        idx <= idx + AW'(1);
      end
    end
  end

  // Query and response bookkeeping registers
  logic signed [15:0] q_px, q_py;
  logic [13:0]        q_r;
  logic               res_status;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      q_px       <= req.pos_x;
      q_py       <= req.pos_y;
      q_r        <= req.radius;
      res_status <= (req.command == cwc_pkg::CMD_ADD) && full;
    end
  end

  // Border test, strict on all four sides
  logic signed [17:0] lo_x, hi_x, lo_y, hi_y;
  logic               bound_exit;

  assign lo_x = 18'(q_px) - $signed({4'b0000, q_r});
  assign hi_x = 18'(q_px) + $signed({4'b0000, q_r});
  assign lo_y = 18'(q_py) - $signed({4'b0000, q_r});
  assign hi_y = 18'(q_py) + $signed({4'b0000, q_r});
  assign bound_exit = (lo_x < 18'sd0) || (hi_x > $signed({3'b000, map_w})) ||
                      (lo_y < 18'sd0) || (hi_y > $signed({3'b000, map_h}));

  // Segment test pipeline
  logic pipe_hit_valid, pipe_hit, pipe_busy;

  cwc_wall_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .wall_valid (rd_valid),
    .wall       (rd_wall),
    .px         (q_px),
    .py         (q_py),
    .radius     (q_r),
    .hit_valid  (pipe_hit_valid),
    .hit        (pipe_hit),
    .busy       (pipe_busy)
  );

  // Hit accumulator
  logic hit_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_acc <= 1'b0;
    end else if (cmd.take) begin
      hit_acc <= 1'b0;
    end else if (cmd.check) begin
      hit_acc <= bound_exit;
    end else if (pipe_hit_valid && pipe_hit) begin
      hit_acc <= 1'b1;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (cmd.reply) begin
      rsp <= '{collides: hit_acc, status: res_status};
    end
  end

  // Status back to the controller
  assign stat.is_query   = (req.command == cwc_pkg::CMD_QUERY);
  assign stat.bound_exit = bound_exit;
  assign stat.empty      = (wall_count == '0);
  assign stat.issue_last = ((CW'(idx) + CW'(1)) == wall_count);
  assign stat.pipe_busy  = rd_valid | pipe_busy;

endmodule

/* hw/rtl/cwc_ctrl.sv */
// Controller state machine: request and response handshakes, query sequencing.
// Depends on cwc_pkg for the state, command and status types.
module cwc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  input  cwc_pkg::stat_t stat,
  output cwc_pkg::cmd_t  cmd
);

  cwc_pkg::state_t state, state_next;
  logic            rsp_free;
  logic            rsp_valid_next;

  assign rsp_free = !rsp_valid || !rsp_stall;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cwc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cwc_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = stat.is_query ? cwc_pkg::ST_CHECK : cwc_pkg::ST_REPLY;
        end
      end
      cwc_pkg::ST_CHECK: begin
        state_next = (stat.bound_exit || stat.empty) ? cwc_pkg::ST_REPLY : cwc_pkg::ST_SCAN;
      end
      cwc_pkg::ST_SCAN: begin
        if (stat.issue_last) begin
          state_next = cwc_pkg::ST_DRAIN;
        end
      end
      cwc_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = cwc_pkg::ST_REPLY;
        end
      end
      cwc_pkg::ST_REPLY: begin
        if (rsp_free) begin
          state_next = cwc_pkg::ST_IDLE;
        end
      end
      default: state_next = cwc_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_stall = 1'b1;
    cmd       = '0;
    case (state)
      cwc_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        cmd.take  = req_valid;
      end
      cwc_pkg::ST_CHECK: cmd.check = 1'b1;
      cwc_pkg::ST_SCAN:  cmd.issue = 1'b1;
      cwc_pkg::ST_DRAIN: ;
      cwc_pkg::ST_REPLY: cmd.reply = rsp_free;
      default: ;
    endcase
  end

  // Response valid flag
  always_comb begin
    if (cmd.reply) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

/* hw/rtl/circle_wall_collision_test.sv */
// Circle versus thick-wall collision tester. Each request clears the wall table,
// adds a wall, or queries a circle; each request gives exactly one response.
// Clear and add go from acceptance straight to the reply state. A query that
// leaves the map or finds the table empty goes through the border check to the
// reply state; otherwise the N stored walls are read one per cycle from the
// single table read port into a 5-stage exact test pipeline, which then drains.
// One request is worked on at a time; a finished response waits in its output
// register while the next request is accepted. Map sizes are to be written
// through the configuration port only while the block is idle; the block
// itself does not enforce this. Depends on cwc_pkg, cwc_ctrl, cwc_datapath.
module circle_wall_collision_test #(
  parameter int MAX_WALLS = cwc_pkg::MAX_WALLS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cwc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cwc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  cwc_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output cwc_pkg::rsp_t                   rsp
);

  cwc_pkg::cmd_t  cmd;
  cwc_pkg::stat_t stat;

  cwc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cwc_datapath #(
    .MAX_WALLS (MAX_WALLS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule

/* hw/rtl/cwc_checker.sv */
// Port-level checks for the collision tester, bound to the top level.
// Depends on cwc_pkg for the response type.
module cwc_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input cwc_pkg::rsp_t rsp
);

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // A full-table flag only comes with a non-hit
  a_rsp_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.collides && rsp.status))
    else $error("collides and status both set");

  // One request at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while busy");

  // A new response only follows work on a request
  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response without a request in progress");

endmodule

bind circle_wall_collision_test cwc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

/* sim/tb_circle_wall_collision_test.sv */
// Self-checking testbench for circle_wall_collision_test: directed table, then random
// clear/add/query episodes under several map sizes, checked against a local wall-table model.
// Depends on cwc_pkg and the circle_wall_collision_test RTL.
`timescale 1ns / 100ps

module tb_circle_wall_collision_test;
  import cwc_pkg::*;

  localparam int TABLE_DEPTH = MAX_WALLS_DEFAULT;
  localparam int REQ_W = $bits(req_t);
  localparam int HANG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    req_t q;
    bit   known;
    rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Local copy of the block state
  wall_t walls[TABLE_DEPTH];
  int unsigned wall_count = 0;
  int map_w = 25600;
  int map_h = 19200;

  rsp_t awaited[$];
  rsp_t oldest;
  int errors = 0;
  int n_sent = 0;
  int gap_free = 0;
  bit quiet = 1'b0;
  int stall_left = 0;
  int calm_left = 0;
  int unsigned idle_cycles = 0;

  circle_wall_collision_test #(.MAX_WALLS(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  // Exact circle vs thick segment test, all in wide integers
  function automatic bit wall_touch(wall_t w, longint px, longint py, longint rad);
    longint dx, dy, wx, wy, bx, by, along, perp;
    bit [63:0] len2, reach, reach2, dist2, twice_perp;
    bit [127:0] lhs, rhs;
    dx = longint'($signed(w.ex)) - longint'($signed(w.sx));
    dy = longint'($signed(w.ey)) - longint'($signed(w.sy));
    wx = px - longint'($signed(w.sx));
    wy = py - longint'($signed(w.sy));
    len2 = dx * dx + dy * dy;
    reach = 2 * rad + longint'(w.th);
    reach2 = reach * reach;
    if (len2 == 0) return 1'b0;
    along = wx * dx + wy * dy;
    // closest point is the start
    if (along <= 0) begin
      dist2 = wx * wx + wy * wy;
      return (4 * dist2) < reach2;
    end
    // closest point is the end
    if (along >= longint'(len2)) begin
      bx = px - longint'($signed(w.ex));
      by = py - longint'($signed(w.ey));
      dist2 = bx * bx + by * by;
      return (4 * dist2) < reach2;
    end
    // interior: compare (2*cross)^2 against reach^2 * len^2
    perp = wx * dy - wy * dx;
    if (perp < 0) perp = -perp;
    twice_perp = 2 * perp;
    lhs = 128'(twice_perp) * 128'(twice_perp);
    rhs = 128'(reach2) * 128'(len2);
    return lhs < rhs;
  endfunction

  // Applies one request to the local wall table and returns the response it gives
  function automatic rsp_t wall_table_step(req_t q);
    rsp_t r;
    longint px, py, rad;
    r = '0;
    case (q.command)
      CMD_CLEAR: wall_count = 0;
      CMD_ADD: begin
        if (wall_count >= TABLE_DEPTH) begin
          r.status = 1'b1;
        end else begin
          walls[wall_count].sx = q.start_x;
          walls[wall_count].sy = q.start_y;
          walls[wall_count].ex = q.end_x;
          walls[wall_count].ey = q.end_y;
          walls[wall_count].th = q.thickness;
          wall_count++;
        end
      end
      CMD_QUERY: begin
        px = longint'($signed(q.pos_x));
        py = longint'($signed(q.pos_y));
        rad = longint'(q.radius);
        if (px - rad < 0 || px + rad > map_w || py - rad < 0 || py + rad > map_h) begin
          r.collides = 1'b1;
        end else begin
          for (int i = 0; i < wall_count; i++)
            if (wall_touch(walls[i], px, py, rad)) r.collides = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] near(longint c, int spread);
    return clip16(c + longint'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // All fields random; callers then fix the parts that matter
  function automatic req_t noise_req();
    req_t q;
    q = REQ_W'({$urandom, $urandom, $urandom, $urandom});
    return q;
  endfunction

  function automatic req_t mk(logic [1:0] cmd, int px, int py, int rad,
                              int sx, int sy, int ex, int ey, int th);
    req_t q;
    q.command = cmd;
    q.pos_x = 16'(px);
    q.pos_y = 16'(py);
    q.radius = 14'(rad);
    q.start_x = 16'(sx);
    q.start_y = 16'(sy);
    q.end_x = 16'(ex);
    q.end_y = 16'(ey);
    q.thickness = 12'(th);
    return q;
  endfunction

  function automatic dir_row_t row(req_t q, bit known, bit col, bit st);
    dir_row_t d;
    d.q = q;
    d.known = known;
    d.want.collides = col;
    d.want.status = st;
    return d;
  endfunction

  // Wall mostly inside the map, sometimes degenerate or very long
  function automatic req_t wall_req();
    req_t q;
    q = noise_req();
    q.command = CMD_ADD;
    q.start_x = 16'($urandom_range(0, map_w));
    q.start_y = 16'($urandom_range(0, map_h));
    case ($urandom_range(0, 9))
      0: begin
        q.end_x = q.start_x;
        q.end_y = q.start_y;
      end
      1: ;
      default: begin
        q.end_x = near($signed(q.start_x), 2000);
        q.end_y = near($signed(q.start_y), 2000);
      end
    endcase
    if ($urandom_range(0, 4) != 0) q.thickness = 12'($urandom_range(0, 400));
    return q;
  endfunction

  // Query aimed near a stored wall most of the time
  function automatic req_t query_req();
    req_t q;
    wall_t w;
    longint cx, cy;
    q = noise_req();
    q.command = CMD_QUERY;
    if (wall_count > 0 && $urandom_range(0, 9) < 6) begin
      w = walls[$urandom_range(0, wall_count - 1)];
      case ($urandom_range(0, 2))
        0: begin
          cx = $signed(w.sx);
          cy = $signed(w.sy);
        end
        1: begin
          cx = $signed(w.ex);
          cy = $signed(w.ey);
        end
        default: begin
          cx = (longint'($signed(w.sx)) + longint'($signed(w.ex))) / 2;
          cy = (longint'($signed(w.sy)) + longint'($signed(w.ey))) / 2;
        end
      endcase
      q.pos_x = near(cx, 500);
      q.pos_y = near(cy, 500);
    end else begin
      q.pos_x = near($urandom_range(0, map_w), 100);
      q.pos_y = near($urandom_range(0, map_h), 100);
    end
    if ($urandom_range(0, 6) != 0) q.radius = 14'($urandom_range(0, 300));
    return q;
  endfunction

  // Drive one request, wait for acceptance, record the expected response
  task automatic issue(input req_t q, input bit known, input rsp_t want);
    rsp_t guess;
    if (gap_free > 0) begin
      gap_free--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      gap_free = $urandom_range(10, 40);
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= q;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    guess = wall_table_step(q);
    awaited.insert(awaited.size(), known ? want : guess);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Both map registers, back to back
  task automatic write_map(input int w, input int h);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAP_WIDTH;
    cfg_data <= 15'(w);
    @(negedge clk);
    cfg_index <= REG_MAP_HEIGHT;
    cfg_data <= 15'(h);
    @(negedge clk);
    cfg_we <= 1'b0;
    map_w = w;
    map_h = h;
  endtask

  // Clear (most of the time), fill (sometimes past full), then probe
  task automatic run_episode();
    req_t q;
    int n_walls, n_probe, pick;
    if ($urandom_range(0, 4) != 0) begin
      q = noise_req();
      q.command = CMD_CLEAR;
      issue(q, 1'b0, '0);
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) n_walls = $urandom_range(0, 12);
    else if (pick < 9) n_walls = $urandom_range(13, 63);
    else n_walls = $urandom_range(64, 68);
    for (int i = 0; i < n_walls; i++) begin
      issue(wall_req(), 1'b0, '0);
      if ($urandom_range(0, 3) == 0) issue(query_req(), 1'b0, '0);
    end
    n_probe = $urandom_range(3, 12);
    for (int i = 0; i < n_probe; i++) begin
      if ($urandom_range(0, 11) == 0) issue(noise_req(), 1'b0, '0);
      else issue(query_req(), 1'b0, '0);
    end
  endtask

  // Response side backpressure in bursts, with calm stretches between
  always @(negedge clk) begin
    if (quiet) begin
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (calm_left > 0) begin
      rsp_stall <= 1'b0;
      calm_left <= calm_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      rsp_stall <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      rsp_stall <= 1'b0;
      calm_left <= $urandom_range(1, 60);
    end
  end

  // Response checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited.size() == 0) begin
        $display("%0t: unexpected response collides=%0b status=%0b",
                 $time, rsp.collides, rsp.status);
        errors++;
      end else begin
        oldest = awaited.pop_front();
        if (rsp.collides !== oldest.collides) begin
          $display("%0t: collides mismatch, expected %0b, got %0b",
                   $time, oldest.collides, rsp.collides);
          errors++;
        end
        if (rsp.status !== oldest.status) begin
          $display("%0t: status mismatch, expected %0b, got %0b",
                   $time, oldest.status, rsp.status);
          errors++;
        end
      end
    end
  end

  // Hang detection: no handshake on either side for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == HANG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    dir_row_t plan[24];
    int phase_w[6];
    int phase_h[6];
    int phase_items[6];
    int goal;

    // Directed rows, default map 25600 x 19200
    plan[0]  = row(mk(CMD_QUERY, 100, 100, 10, 0, 0, 0, 0, 0), 1, 0, 0);
    plan[1]  = row(mk(CMD_QUERY, 0, 0, 0, -1, -1, -1, -1, 4095), 1, 0, 0);
    plan[2]  = row(mk(CMD_QUERY, 25600, 19200, 0, 0, 0, 0, 0, 0), 1, 0, 0);
    plan[3]  = row(mk(CMD_QUERY, 25601, 100, 0, 0, 0, 0, 0, 0), 1, 1, 0);
    plan[4]  = row(mk(CMD_QUERY, 100, 19201, 0, 0, 0, 0, 0, 0), 1, 1, 0);
    plan[5]  = row(mk(CMD_QUERY, -32768, -32768, 0, 0, 0, 0, 0, 0), 1, 1, 0);
    plan[6]  = row(mk(CMD_QUERY, 32767, 32767, 16383, 0, 0, 0, 0, 0), 1, 1, 0);
    plan[7]  = row(mk(CMD_QUERY, 12800, 9600, 16383, 0, 0, 0, 0, 0), 1, 1, 0);
    plan[8]  = row(mk(CMD_UNUSED, -1, -1, 16383, -1, -1, -1, -1, 4095), 1, 0, 0);
    // zero-length wall is stored but never hit
    plan[9]  = row(mk(CMD_ADD, 0, 0, 0, 5000, 5000, 5000, 5000, 4095), 1, 0, 0);
    plan[10] = row(mk(CMD_QUERY, 5000, 5000, 100, 0, 0, 0, 0, 0), 0, 0, 0);
    // horizontal wall, probes right on and just inside the reach
    plan[11] = row(mk(CMD_ADD, 0, 0, 0, 1000, 1000, 3000, 1000, 160), 1, 0, 0);
    plan[12] = row(mk(CMD_QUERY, 2000, 1080, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    plan[13] = row(mk(CMD_QUERY, 2000, 1079, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    plan[14] = row(mk(CMD_QUERY, 900, 1000, 20, 0, 0, 0, 0, 0), 0, 0, 0);
    plan[15] = row(mk(CMD_QUERY, 3050, 1000, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    // wall across the full coordinate range
    plan[16] = row(mk(CMD_ADD, 32767, 32767, 16383, -32768, -32768, 32767, 32767, 4095),
                   1, 0, 0);
    plan[17] = row(mk(CMD_QUERY, 20000, 10000, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    plan[18] = row(mk(CMD_QUERY, 15000, 15000, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    plan[19] = row(mk(CMD_CLEAR, -1, -1, 16383, -1, -1, -1, -1, 4095), 1, 0, 0);
    plan[20] = row(mk(CMD_QUERY, 15000, 15000, 0, 0, 0, 0, 0, 0), 1, 0, 0);
    // zero thickness wall only touches with a positive radius
    plan[21] = row(mk(CMD_ADD, 0, 0, 0, 100, 100, 200, 200, 0), 1, 0, 0);
    plan[22] = row(mk(CMD_QUERY, 150, 150, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    plan[23] = row(mk(CMD_QUERY, 150, 151, 1, 0, 0, 0, 0, 0), 0, 0, 0);

    // Map settings per random phase; the last one runs without idling
    phase_w = '{32767, 0, $urandom_range(1, 32766), 640, 32767, 25600};
    phase_h = '{32767, 0, $urandom_range(1, 32766), 32767, 480, 19200};
    phase_items = '{170, 40, 170, 170, 170, 150};

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) issue(plan[i].q, plan[i].known, plan[i].want);
    drain_responses();

    for (int p = 0; p < 6; p++) begin
      if (p == 5) quiet = 1'b1;
      write_map(phase_w[p], phase_h[p]);
      goal = n_sent + phase_items[p];
      while (n_sent < goal) run_episode();
      drain_responses();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
